FILE: rtl/core/scam_pkg.sv
// ----------------------------------------------------------------------------
// scam_pkg
// Shared types and codes for the symbol table CAM: request and result
// encodings, the request record and the back-end state type.
// ----------------------------------------------------------------------------
package scam_pkg;

    localparam int KIND_W   = 3;
    localparam int HEAD_W   = 64;
    localparam int TAIL_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;

    // request kind codes as they arrive on the port
    localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOD_LABEL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MOD_ADDR  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MOD_BOTH  = 3'd5;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_SEARCH,
        OP_DELETE,
        OP_MOD_LABEL,
        OP_MOD_ADDR,
        OP_MOD_BOTH,
        OP_IGNORE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE,
        ST_DUPLICATE,
        ST_NOT_FOUND,
        ST_FULL
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        op_t                      op;
        logic [HEAD_W-1:0]        head;
        logic [TAIL_W-1:0]        tail;
        logic [HEAD_W-1:0]        new_head;
        logic [TAIL_W-1:0]        new_tail;
        logic signed [ADDR_W-1:0] addr;
    } req_t;

endpackage

FILE: rtl/core/scam_fifo.sv
// ----------------------------------------------------------------------------
// scam_fifo
// Small register queue with push/full and pop/empty sides; the head entry
// is visible on rdata while empty is low.
// ----------------------------------------------------------------------------
module scam_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/scam_front.sv
// ----------------------------------------------------------------------------
// scam_front
// Request classifier: maps the kind code to an operation and trims both
// labels at their first zero character.
// ----------------------------------------------------------------------------
module scam_front
    import scam_pkg::*;
(
    input  logic [KIND_W-1:0]        kind,
    input  logic [HEAD_W-1:0]        label_head,
    input  logic [TAIL_W-1:0]        label_tail,
    input  logic [HEAD_W-1:0]        new_label_head,
    input  logic [TAIL_W-1:0]        new_label_tail,
    input  logic signed [ADDR_W-1:0] address_value,
    output req_t                     req
);

    // zero every byte from the first zero character on, tail included
    function automatic logic [HEAD_W+TAIL_W-1:0] trim_label(
        input logic [HEAD_W-1:0] head,
        input logic [TAIL_W-1:0] tail
    );
        logic              keep;
        logic [HEAD_W-1:0] head_t;
        logic [TAIL_W-1:0] tail_t;
        keep   = 1'b1;
        head_t = '0;
        for (int i = 0; i < HEAD_W / 8; i++)
        begin
            if (head[8*i +: 8] == 8'd0)
            begin
                keep = 1'b0;
            end
            head_t[8*i +: 8] = keep ? head[8*i +: 8] : 8'd0;
        end
        tail_t = keep ? tail : '0;
        return {head_t, tail_t};
    endfunction

    op_t op;

    always_comb
    begin
        unique case (kind)
            KIND_INSERT:    op = OP_INSERT;
            KIND_SEARCH:    op = OP_SEARCH;
            KIND_DELETE:    op = OP_DELETE;
            KIND_MOD_LABEL: op = OP_MOD_LABEL;
            KIND_MOD_ADDR:  op = OP_MOD_ADDR;
            KIND_MOD_BOTH:  op = OP_MOD_BOTH;
            default:        op = OP_IGNORE;
        endcase
    end

    always_comb
    begin
        req.op                     = op;
        {req.head, req.tail}       = trim_label(label_head, label_tail);
        {req.new_head, req.new_tail} = trim_label(new_label_head, new_label_tail);
        req.addr                   = address_value;
    end

endmodule

FILE: rtl/core/scam_back.sv
// ----------------------------------------------------------------------------
// scam_back
// Table engine: compares all live entries against the request label as it
// takes a request, then applies insert, delete-with-compaction or modify.
// ----------------------------------------------------------------------------
module scam_back
    import scam_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int LVL   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int RES_W = STATUS_W + 1 + CNT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             req,
    input  logic             req_empty,
    output logic             req_pop,
    output logic [RES_W-1:0] res_data,
    output logic             res_push,
    input  logic             res_full
);

    logic [HEAD_W-1:0]        label_reg [TABLE_DEPTH];
    logic [HEAD_W-1:0]        label_next [TABLE_DEPTH];
    logic [TAIL_W-1:0]        tail_reg [TABLE_DEPTH];
    logic [TAIL_W-1:0]        tail_next [TABLE_DEPTH];
    logic signed [ADDR_W-1:0] addr_reg [TABLE_DEPTH];
    logic signed [ADDR_W-1:0] addr_next [TABLE_DEPTH];

    back_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    req_t                     req_reg, req_next;
    logic [TABLE_DEPTH-1:0]   match_reg, match_next;

    logic [TABLE_DEPTH-1:0]   live_mask;
    logic [TABLE_DEPTH-1:0]   match_now;
    logic [TABLE_DEPTH-1:0]   after_first;
    logic                     present;
    status_t                  res_status;
    logic                     res_found;

    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            live_mask[k] = (CNT_W'(k) < count_reg);
            match_now[k] = live_mask[k] && (label_reg[k] == req.head)
                           && (tail_reg[k] == req.tail);
        end
    end

    // prefix OR: every entry at or above the first match moves down on delete
    always_comb
    begin
        after_first = match_reg;
        for (int lvl = 0; lvl < LVL; lvl++)
        begin
            after_first = after_first | (after_first << (1 << lvl));
        end
    end

    assign present = |match_reg;

    always_comb
    begin
        res_status = ST_DONE;
        res_found  = present;
        case (req_reg.op)
            OP_INSERT:
            begin
                if (present)
                begin
                    res_status = ST_DUPLICATE;
                end
                else if (count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    res_status = ST_FULL;
                end
            end
            OP_DELETE, OP_MOD_LABEL, OP_MOD_ADDR, OP_MOD_BOTH:
            begin
                if (!present)
                begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_IGNORE:
            begin
                res_found = 1'b0;
            end
            default:
            begin
                res_status = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next   = req_reg;
        match_next = match_reg;
        label_next = label_reg;
        tail_next  = tail_reg;
        addr_next  = addr_reg;
        req_pop    = 1'b0;
        res_push   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!req_empty)
                begin
                    req_pop    = 1'b1;
                    req_next   = req;
                    match_next = match_now;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                // hold until the result queue has room
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = BK_IDLE;
                    if (res_status == ST_DONE)
                    begin
                        case (req_reg.op)
                            OP_INSERT:
                            begin
                                for (int k = 0; k < TABLE_DEPTH; k++)
                                begin
                                    if (count_reg == CNT_W'(k))
                                    begin
                                        label_next[k] = req_reg.head;
                                        tail_next[k]  = req_reg.tail;
                                        addr_next[k]  = req_reg.addr;
                                    end
                                end
                                count_next = count_reg + 1'b1;
                            end
                            OP_DELETE:
                            begin
                                for (int k = 0; k < TABLE_DEPTH - 1; k++)
                                begin
                                    if (after_first[k])
                                    begin
                                        label_next[k] = label_reg[k+1];
                                        tail_next[k]  = tail_reg[k+1];
                                        addr_next[k]  = addr_reg[k+1];
                                    end
                                end
                                count_next = count_reg - 1'b1;
                            end
                            OP_MOD_LABEL, OP_MOD_ADDR, OP_MOD_BOTH:
                            begin
                                for (int k = 0; k < TABLE_DEPTH; k++)
                                begin
                                    if (match_reg[k])
                                    begin
                                        if (req_reg.op != OP_MOD_ADDR)
                                        begin
                                            label_next[k] = req_reg.new_head;
                                            tail_next[k]  = req_reg.new_tail;
                                        end
                                        if (req_reg.op != OP_MOD_LABEL)
                                        begin
                                            addr_next[k] = req_reg.addr;
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                                count_next = count_reg;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign res_data = {res_status, res_found, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        match_reg <= match_next;
        label_reg <= label_next;
        tail_reg  <= tail_next;
        addr_reg  <= addr_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_match_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EXEC) |-> ((match_reg & ~live_mask) == '0))
        else $error("match on an entry beyond the fill count");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && req_reg.op == OP_DELETE && present)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("delete did not drop the entry count");

    a_refused_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && req_reg.op == OP_INSERT && res_status != ST_DONE)
        |=> $stable(count_reg))
        else $error("refused insert changed the entry count");

    a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |=> (state_reg == BK_EXEC && !req_pop))
        else $error("request taken while another is in flight");

endmodule

FILE: rtl/core/symbol_table_cam.sv
// ----------------------------------------------------------------------------
// symbol_table_cam
// Bounded label-to-address table kept in insertion order, with insert,
// search, delete and modify requests and one result per request.
// ----------------------------------------------------------------------------
// Each request passes the table engine in order: as it is taken, its label
// is compared against every live entry at once and the matches registered;
// then the table is written, rewritten or compacted and the result produced,
// holding while the result queue is full. One request is handled at a time.
// A two-entry request queue and a two-entry result queue let the input and
// output sides stall independently. The table is empty right after reset;
// no clearing pass is needed, since only entries below the fill count are
// ever compared. entry_count is $clog2(TABLE_DEPTH+1) bits wide.
module symbol_table_cam
    import scam_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [KIND_W-1:0]        kind,
    input  logic [HEAD_W-1:0]        label_head,
    input  logic [TAIL_W-1:0]        label_tail,
    input  logic [HEAD_W-1:0]        new_label_head,
    input  logic [TAIL_W-1:0]        new_label_tail,
    input  logic signed [ADDR_W-1:0] address_value,
    output logic                     empty,
    input  logic                     pop,
    output logic [STATUS_W-1:0]      status,
    output logic                     found,
    output logic [CNT_W-1:0]         entry_count
);

    localparam int REQ_W = $bits(req_t);
    localparam int RES_W = STATUS_W + 1 + CNT_W;

    req_t             req_in;
    logic [REQ_W-1:0] req_q_data;
    logic             req_empty;
    logic             req_pop;
    logic [RES_W-1:0] res_wdata;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_rdata;

    scam_front u_front (
        .kind           (kind),
        .label_head     (label_head),
        .label_tail     (label_tail),
        .new_label_head (new_label_head),
        .new_label_tail (new_label_tail),
        .address_value  (address_value),
        .req            (req_in)
    );

    scam_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (2)
    ) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (req_in),
        .full  (full),
        .pop   (req_pop),
        .rdata (req_q_data),
        .empty (req_empty)
    );

    scam_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_t'(req_q_data)),
        .req_empty (req_empty),
        .req_pop   (req_pop),
        .res_data  (res_wdata),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    scam_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign {status, found, entry_count} = res_rdata;

endmodule
